// ===== hdl/sawin_pkg.sv =====
// Package for the selective-ack retransmit window: types, codes and widths.
`default_nettype none
package sawin_pkg;

    localparam int MAX_WINDOW_DEF = 32;
    localparam int ACK_SPAN       = 32;
    localparam int MASK_W         = ACK_SPAN + 1;
    localparam int IDX_W          = 6;

    // request codes
    localparam logic [1:0] REQ_SEND    = 2'd0;
    localparam logic [1:0] REQ_ACK     = 2'd1;
    localparam logic [1:0] REQ_COLLECT = 2'd2;

    // result status codes
    localparam logic [2:0] ST_SENT = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_ACK  = 3'd2;
    localparam logic [2:0] ST_RETX = 3'd3;
    localparam logic [2:0] ST_NONE = 3'd4;

    // configuration register indexes
    localparam logic CFG_WINDOW_LIMIT = 1'b0;
    localparam logic CFG_INTERVAL     = 1'b1;

    // operations broadcast to the cell row
    localparam logic [2:0] OP_HOLD  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_MATCH = 3'd2;
    localparam logic [2:0] OP_WALK  = 3'd3;
    localparam logic [2:0] OP_SHIFT = 3'd4;
    localparam logic [2:0] OP_DUE   = 3'd5;
    localparam logic [2:0] OP_EMIT  = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] tick;
        logic [15:0] payload_handle;
        logic [15:0] ack_sequence;
        logic [31:0] ack_bits;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] sequence_res;
        logic [15:0] out_handle;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] seq;
        logic [63:0] tick;
        logic [15:0] handle;
    } entry_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [63:0]       tick;
        logic [15:0]       handle;
        logic [15:0]       seq;
        logic [15:0]       ack_seq;
        logic [31:0]       ack_bits;
        logic [31:0]       interval;
        logic [MASK_W-1:0] mask;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/selective_ack_retransmit_window.sv =====
// Top level: sender-side selective-ack retransmit window over a row of cells.
//
// Input channel (in_valid/in_stall/in_data) takes one request item at a time;
// output channel (out_valid/out_stall/out_data) returns its result items.
// Send: accepted and answered with one result (full window -> status full).
// Ack: match all cells in parallel, then a token walks the row one cell per
//   cycle so the oldest holder of each sequence is marked, then each removed
//   entry is closed up in turn, and then the ack result follows.
// Collect: flag due entries in every cell, then one retransmit item per cycle
//   while the output is not stalled, oldest first, or one "nothing due" item.
// The walk and compaction over the cell row and the output handshake set the
// ack time; the due entries and the output handshake set the collect time.
// A result sits in one output register; a stalled receiver holds it and the
// block waits to push its next result until the item is taken. in_stall is
// low only when idle with the output register free or draining.
// Reset empties the window, zeroes the sequence counter and loads
// window_limit = 32, retransmit_interval = 10. No clearing pass is needed.
// Configuration writes (cfg_we/cfg_index/cfg_data) are registered.
`default_nettype none
module selective_ack_retransmit_window
#(
    parameter int MAX_WINDOW = sawin_pkg::MAX_WINDOW_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire sawin_pkg::in_item_t   in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output sawin_pkg::out_item_t       out_data,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [31:0]           cfg_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;

    logic [2:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              walk_reg, walk_next;
    logic [15:0]                   nseq_reg, nseq_next;
    logic [5:0]                    limit_reg;
    logic [31:0]                   interval_reg;
    logic [sawin_pkg::MASK_W-1:0]  mask_reg, mask_next;
    logic                          ovalid_reg, ovalid_next;
    sawin_pkg::out_item_t          out_reg, out_next;
    sawin_pkg::in_item_t           held_reg;

    sawin_pkg::cell_ctrl_t         ctrl;
    logic                          accept, out_free, push, full;
    sawin_pkg::out_item_t          res;

    sawin_pkg::entry_t             cell_entry [MAX_WINDOW];
    logic                          cell_kill  [MAX_WINDOW];
    logic                          cell_tok   [MAX_WINDOW];
    logic                          cell_sel   [MAX_WINDOW];
    logic                          cell_more  [MAX_WINDOW];
    logic [sawin_pkg::MASK_W-1:0]  cell_claim [MAX_WINDOW];
    logic                          kill_chain [MAX_WINDOW+1];
    logic                          due_chain  [MAX_WINDOW+1];

    logic [sawin_pkg::MASK_W-1:0]  claim_or;
    logic [15:0]                   emit_seq, emit_handle;
    logic                          due_more_any;

    assign kill_chain[0] = 1'b0;
    assign due_chain[0]  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++)
        begin : g_cell
            sawin_pkg::entry_t up_entry;
            logic              up_kill;
            logic              tok_in;
            if (g == MAX_WINDOW - 1)
            begin : g_top
                assign up_entry = '0;
                assign up_kill  = 1'b0;
            end
            else
            begin : g_mid
                assign up_entry = cell_entry[g+1];
                assign up_kill  = cell_kill[g+1];
            end
            if (g == 0)
            begin : g_first
                assign tok_in = (ctrl.op == sawin_pkg::OP_MATCH);
            end
            else
            begin : g_rest
                assign tok_in = cell_tok[g-1];
            end

            sawin_cell u_cell
            (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctrl           (ctrl),
                .occ            (count_reg > CNT_W'(g)),
                .wsel           (count_reg == CNT_W'(g)),
                .up_entry       (up_entry),
                .up_kill        (up_kill),
                .kill_below_in  (kill_chain[g]),
                .due_below_in   (due_chain[g]),
                .tok_in         (tok_in),
                .entry          (cell_entry[g]),
                .kill           (cell_kill[g]),
                .kill_below_out (kill_chain[g+1]),
                .due_below_out  (due_chain[g+1]),
                .tok_out        (cell_tok[g]),
                .emit_sel       (cell_sel[g]),
                .due_more       (cell_more[g]),
                .claim          (cell_claim[g])
            );
        end
    endgenerate

    // gather per-cell outputs; only one cell has the token or the emit select
    always_comb
    begin
        claim_or     = '0;
        emit_seq     = '0;
        emit_handle  = '0;
        due_more_any = 1'b0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            claim_or     = claim_or | cell_claim[i];
            emit_seq     = emit_seq | (cell_sel[i] ? cell_entry[i].seq : 16'd0);
            emit_handle  = emit_handle | (cell_sel[i] ? cell_entry[i].handle : 16'd0);
            due_more_any = due_more_any | cell_more[i];
        end
    end

    assign out_free = !ovalid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;
    assign full     = ({1'b0, limit_reg} <= 7'(count_reg))
                      || (count_reg >= CNT_W'(MAX_WINDOW));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        walk_next  = walk_reg;
        nseq_next  = nseq_reg;
        mask_next  = mask_reg;
        push       = 1'b0;
        res        = '0;
        res.last   = 1'b1;

        ctrl          = '0;
        ctrl.op       = sawin_pkg::OP_HOLD;
        ctrl.tick     = held_reg.tick;
        ctrl.handle   = in_data.payload_handle;
        ctrl.seq      = nseq_reg;
        ctrl.ack_seq  = in_data.ack_sequence;
        ctrl.ack_bits = in_data.ack_bits;
        ctrl.interval = interval_reg;
        ctrl.mask     = mask_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.tick = in_data.tick;
                    case (in_data.req_type)
                        sawin_pkg::REQ_SEND:
                        begin
                            push = 1'b1;
                            if (full)
                                res.status = sawin_pkg::ST_FULL;
                            else
                            begin
                                ctrl.op          = sawin_pkg::OP_WRITE;
                                res.status       = sawin_pkg::ST_SENT;
                                res.sequence_res = nseq_reg;
                                nseq_next        = nseq_reg + 16'd1;
                                count_next       = count_reg + 1'b1;
                            end
                        end
                        sawin_pkg::REQ_ACK:
                        begin
                            ctrl.op   = sawin_pkg::OP_MATCH;
                            mask_next = '0;
                            walk_next = '0;
                            state_next = (count_reg == '0) ? S_SHIFT : S_WALK;
                        end
                        sawin_pkg::REQ_COLLECT:
                        begin
                            ctrl.op    = sawin_pkg::OP_DUE;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            push       = 1'b1;
                            res.status = sawin_pkg::ST_NONE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                ctrl.op   = sawin_pkg::OP_WALK;
                mask_next = mask_reg | claim_or;
                walk_next = walk_reg + 1'b1;
                if (walk_reg == count_reg - 1'b1)
                    state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                // one removed entry closed up per cycle, lowest first
                if (kill_chain[MAX_WINDOW])
                begin
                    ctrl.op    = sawin_pkg::OP_SHIFT;
                    count_next = count_reg - 1'b1;
                end
                else if (out_free)
                begin
                    push       = 1'b1;
                    res.status = sawin_pkg::ST_ACK;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    push = 1'b1;
                    if (due_chain[MAX_WINDOW])
                    begin
                        ctrl.op          = sawin_pkg::OP_EMIT;
                        res.status       = sawin_pkg::ST_RETX;
                        res.sequence_res = emit_seq;
                        res.out_handle   = emit_handle;
                        res.last         = !due_more_any;
                        if (!due_more_any)
                            state_next = S_IDLE;
                    end
                    else
                    begin
                        res.status = sawin_pkg::ST_NONE;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (push)
        begin
            ovalid_next = 1'b1;
            out_next    = res;
        end
        else
        begin
            ovalid_next = ovalid_reg && out_stall;
            out_next    = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            walk_reg     <= '0;
            nseq_reg     <= '0;
            mask_reg     <= '0;
            ovalid_reg   <= 1'b0;
            limit_reg    <= 6'd32;
            interval_reg <= 32'd10;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            walk_reg   <= walk_next;
            nseq_reg   <= nseq_next;
            mask_reg   <= mask_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sawin_pkg::CFG_WINDOW_LIMIT: limit_reg    <= cfg_data[5:0];
                    sawin_pkg::CFG_INTERVAL:     interval_reg <= cfg_data;
                    default:                     limit_reg    <= limit_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
            held_reg <= in_data;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== hdl/sawin_cell.sv =====
// One cell of the in-flight row: holds one entry plus ack and due flags.
`default_nettype none
module sawin_cell
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire sawin_pkg::cell_ctrl_t     ctrl,
    input  wire logic                      occ,
    input  wire logic                      wsel,
    input  wire sawin_pkg::entry_t         up_entry,
    input  wire logic                      up_kill,
    input  wire logic                      kill_below_in,
    input  wire logic                      due_below_in,
    input  wire logic                      tok_in,
    output sawin_pkg::entry_t              entry,
    output logic                           kill,
    output logic                           kill_below_out,
    output logic                           due_below_out,
    output logic                           tok_out,
    output logic                           emit_sel,
    output logic                           due_more,
    output logic [sawin_pkg::MASK_W-1:0]   claim
);

    sawin_pkg::entry_t                entry_reg;
    logic                             hit_reg, kill_reg, due_reg, tok_reg;
    logic [sawin_pkg::IDX_W-1:0]      idx_reg;

    logic [15:0]                      seq_gap, seq_gap_m1;
    logic                             hit_now;
    logic [sawin_pkg::IDX_W-1:0]      idx_now;
    logic [63:0]                      age;
    logic                             due_now;
    logic                             take;

    always_comb
    begin
        seq_gap    = ctrl.ack_seq - entry_reg.seq;
        seq_gap_m1 = seq_gap - 16'd1;
        if (seq_gap == 16'd0)
        begin
            hit_now = occ;
            idx_now = '0;
        end
        else
        begin
            hit_now = occ && (seq_gap_m1 < 16'd32) && ctrl.ack_bits[seq_gap_m1[4:0]];
            idx_now = sawin_pkg::IDX_W'(seq_gap_m1[4:0]) + 1'b1;
        end
        age     = ctrl.tick - entry_reg.tick;
        due_now = occ && (ctrl.tick >= entry_reg.tick) && (age >= {32'd0, ctrl.interval});
        take    = kill_below_in || kill_reg;
        // claim the handled sequence if no older entry has taken it yet
        if (tok_reg && hit_reg && !ctrl.mask[idx_reg])
            claim = sawin_pkg::MASK_W'(1) << idx_reg;
        else
            claim = '0;
    end

    assign entry          = entry_reg;
    assign kill           = kill_reg;
    assign kill_below_out = kill_below_in || (kill_reg && occ);
    assign due_below_out  = due_below_in || due_reg;
    assign tok_out        = tok_reg;
    assign emit_sel       = due_reg && !due_below_in;
    assign due_more       = due_reg && due_below_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            kill_reg <= 1'b0;
            due_reg  <= 1'b0;
            tok_reg  <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            case (ctrl.op)
                sawin_pkg::OP_MATCH:
                begin
                    hit_reg  <= hit_now;
                    idx_reg  <= idx_now;
                    kill_reg <= 1'b0;
                    tok_reg  <= tok_in;
                end
                sawin_pkg::OP_WALK:
                begin
                    tok_reg <= tok_in;
                    if (claim != '0)
                        kill_reg <= 1'b1;
                end
                sawin_pkg::OP_SHIFT:
                begin
                    if (take)
                        kill_reg <= up_kill;
                end
                sawin_pkg::OP_DUE:
                    due_reg <= due_now;
                sawin_pkg::OP_EMIT:
                begin
                    if (emit_sel)
                        due_reg <= 1'b0;
                end
                default:
                    tok_reg <= 1'b0;
            endcase
        end
    end

    // entry payload, no reset
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            sawin_pkg::OP_WRITE:
            begin
                if (wsel)
                begin
                    entry_reg.seq    <= ctrl.seq;
                    entry_reg.tick   <= ctrl.tick;
                    entry_reg.handle <= ctrl.handle;
                end
            end
            sawin_pkg::OP_SHIFT:
            begin
                if (take)
                    entry_reg <= up_entry;
            end
            sawin_pkg::OP_EMIT:
            begin
                if (emit_sel)
                    entry_reg.tick <= ctrl.tick;
            end
            default:
                entry_reg <= entry_reg;
        endcase
    end

endmodule
`default_nettype wire
